// ===== rtl/mcst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcst_pkg;

    // Default frame format
    localparam int DATA_BITS_DEF   = 8;
    localparam int STOP_BITS_DEF   = 2;
    localparam int FRAME_BYTES_DEF = 4;

    // Bytes actually built per command; later bytes of a longer frame are zero
    localparam int BUILT_BYTES = 4;

    // Register indexes on the config port
    localparam logic [7:0] CFG_START_BYTE   = 8'd0;
    localparam logic [7:0] CFG_DEVICE_BYTE  = 8'd1;
    localparam logic [7:0] CFG_MOTOR_A_CODE = 8'd2;
    localparam logic [7:0] CFG_MOTOR_B_CODE = 8'd3;
    localparam logic [7:0] CFG_FORWARD_CODE = 8'd4;
    localparam logic [7:0] CFG_REVERSE_CODE = 8'd5;
    localparam logic [7:0] CFG_SPEED_MAX    = 8'd6;
    localparam logic [7:0] CFG_BIT_TICKS    = 8'd7;

    // Motor select codes
    localparam logic [1:0] SEL_MOTOR_A = 2'd0;
    localparam logic [1:0] SEL_MOTOR_B = 2'd1;

    // Action codes
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // Speed path: clamp, then x/100 as (x * 5243) >> 19, exact for x < 2^15
    localparam logic [6:0]  SPEED_CLAMP = 7'd100;
    localparam int          RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam int          COEF_W      = 21;
    localparam logic [7:0]  SPEED_MASK  = 8'h7F;

    // Reset values of the registers
    localparam logic [7:0] RST_START_BYTE   = 8'd128;
    localparam logic [7:0] RST_DEVICE_BYTE  = 8'd0;
    localparam logic [7:0] RST_MOTOR_A_CODE = 8'd2;
    localparam logic [7:0] RST_MOTOR_B_CODE = 8'd6;
    localparam logic [7:0] RST_FORWARD_CODE = 8'd0;
    localparam logic [7:0] RST_REVERSE_CODE = 8'd1;
    localparam logic [7:0] RST_SPEED_MAX    = 8'd127;
    localparam logic [7:0] RST_BIT_TICKS    = 8'd10;

    typedef logic [7:0] t_byte;
    typedef t_byte t_frame [BUILT_BYTES];

    // Configuration as seen by the command encoder
    typedef struct packed {
        t_byte               start_byte;
        t_byte               device_byte;
        t_byte               motor_a_code;
        t_byte               motor_b_code;
        t_byte               forward_code;
        t_byte               reverse_code;
        logic [COEF_W-1:0]   speed_coef;   // speed_max * RECIP_100
    } t_cfg;

    function automatic logic [COEF_W-1:0] speed_coef_of(input t_byte speed_max);
        return COEF_W'(speed_max) * COEF_W'(RECIP_100);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mcst_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command / tick input channel
interface mcst_cmd_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [1:0]  motor_select;
    logic signed [15:0] signed_speed;

    modport source (output valid, output action, output motor_select,
                    output signed_speed, input ready);
    modport sink   (input valid, input action, input motor_select,
                    input signed_speed, output ready);
endinterface

// Result channel
interface mcst_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic command_rejected;

    modport source (output valid, output line_level, output busy_res,
                    output command_rejected, input ready);
    modport sink   (input valid, input line_level, input busy_res,
                    input command_rejected, output ready);
endinterface

// Register write channel
interface mcst_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mcst_cmd_enc.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Builds the command frame: start, device, motor|direction, scaled speed
module mcst_cmd_enc
    import mcst_pkg::*;
(
    input  t_cfg               i_cfg,
    input  logic [1:0]         i_motor_select,
    input  logic signed [15:0] i_signed_speed,
    output t_frame             o_frame
);

    logic                      neg;
    logic [15:0]               mag_full;
    logic [6:0]                mag;
    logic [COEF_W+6:0]         prod;
    t_byte                     spd;
    t_byte                     motor_code;
    t_byte                     dir_code;

    // Magnitude, clamped to full scale
    assign neg      = i_signed_speed[15];
    assign mag_full = neg ? (16'd0 - 16'(i_signed_speed)) : 16'(i_signed_speed);
    assign mag      = (mag_full > 16'(SPEED_CLAMP)) ? SPEED_CLAMP : mag_full[6:0];

    // mag * speed_max / 100 via precomputed reciprocal coefficient
    assign prod = (COEF_W+7)'(mag) * (COEF_W+7)'(i_cfg.speed_coef);
    assign spd  = prod[RECIP_SHIFT +: 8];

    assign motor_code = (i_motor_select == SEL_MOTOR_A) ? i_cfg.motor_a_code
                                                        : i_cfg.motor_b_code;
    assign dir_code   = neg ? i_cfg.reverse_code : i_cfg.forward_code;

    always_comb begin
        o_frame[0] = i_cfg.start_byte;
        o_frame[1] = i_cfg.device_byte;
        o_frame[2] = motor_code | dir_code;
        o_frame[3] = spd & SPEED_MASK;
    end

endmodule

`default_nettype wire

// ===== rtl/motor_command_serial_tx.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Each accepted command or tick yields one registered result transaction.
// Throughput: one item per cycle unless o_res stalls; a result frees as it is taken.
// Line timing: each serial bit lasts bit_ticks tick items (0 behaves as 1).
// Reset (synchronous, active low): registers to defaults, line idle high, not busy,
// no result pending.
module motor_command_serial_tx
    import mcst_pkg::*;
#(
    parameter int DATA_BITS   = DATA_BITS_DEF,
    parameter int STOP_BITS   = STOP_BITS_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mcst_cmd_if.sink   i_cmd,
    mcst_res_if.source o_res,
    mcst_cfg_if.sink   i_cfg
);

    localparam int SLOT_COUNT = 1 + DATA_BITS + STOP_BITS;
    localparam int BIT_IDX_W  = $clog2(SLOT_COUNT);
    localparam int BYTE_IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    // Configuration registers
    t_cfg  r_cfg;
    t_byte r_bit_ticks;

    // Transmit state
    t_frame                r_frame,    n_frame;
    logic [BYTE_IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [BIT_IDX_W-1:0]  r_bit_idx,  n_bit_idx;
    t_byte                 r_tick_cnt, n_tick_cnt;
    logic                  r_sending,  n_sending;

    // Result register
    logic r_out_valid;
    logic r_line, n_line;
    logic r_busy;
    logic r_rej,  n_rej;

    t_frame                enc_frame;
    logic                  accept;
    t_byte                 period;
    t_byte                 tick_inc;
    logic [BIT_IDX_W-1:0]  data_pos;
    logic [1:0]            byte_sel;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign period      = (r_bit_ticks == 8'd0) ? 8'd1 : r_bit_ticks;
    assign tick_inc    = r_tick_cnt + 8'd1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte   <= RST_START_BYTE;
            r_cfg.device_byte  <= RST_DEVICE_BYTE;
            r_cfg.motor_a_code <= RST_MOTOR_A_CODE;
            r_cfg.motor_b_code <= RST_MOTOR_B_CODE;
            r_cfg.forward_code <= RST_FORWARD_CODE;
            r_cfg.reverse_code <= RST_REVERSE_CODE;
            r_cfg.speed_coef   <= speed_coef_of(RST_SPEED_MAX);
            r_bit_ticks        <= RST_BIT_TICKS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_START_BYTE:   r_cfg.start_byte   <= i_cfg.data;
                CFG_DEVICE_BYTE:  r_cfg.device_byte  <= i_cfg.data;
                CFG_MOTOR_A_CODE: r_cfg.motor_a_code <= i_cfg.data;
                CFG_MOTOR_B_CODE: r_cfg.motor_b_code <= i_cfg.data;
                CFG_FORWARD_CODE: r_cfg.forward_code <= i_cfg.data;
                CFG_REVERSE_CODE: r_cfg.reverse_code <= i_cfg.data;
                CFG_SPEED_MAX:    r_cfg.speed_coef   <= speed_coef_of(i_cfg.data);
                CFG_BIT_TICKS:    r_bit_ticks        <= i_cfg.data;
                default: ;
            endcase
        end
    end

    mcst_cmd_enc u_enc (
        .i_cfg          (r_cfg),
        .i_motor_select (i_cmd.motor_select),
        .i_signed_speed (i_cmd.signed_speed),
        .o_frame        (enc_frame)
    );

    // Next transmit state for the accepted item
    always_comb begin
        n_frame    = r_frame;
        n_byte_idx = r_byte_idx;
        n_bit_idx  = r_bit_idx;
        n_tick_cnt = r_tick_cnt;
        n_sending  = r_sending;
        n_rej      = 1'b0;
        if (i_cmd.action == ACT_COMMAND) begin
            if (r_sending) begin
                n_rej = 1'b1;
            end else if (i_cmd.motor_select == SEL_MOTOR_A ||
                         i_cmd.motor_select == SEL_MOTOR_B) begin
                n_frame    = enc_frame;
                n_byte_idx = '0;
                n_bit_idx  = '0;
                n_tick_cnt = '0;
                n_sending  = 1'b1;
            end
        end else if (r_sending) begin
            n_tick_cnt = tick_inc;
            if (tick_inc >= period) begin
                n_tick_cnt = '0;
                if (r_bit_idx == BIT_IDX_W'(SLOT_COUNT - 1)) begin
                    n_bit_idx = '0;
                    if (r_byte_idx == BYTE_IDX_W'(FRAME_BYTES - 1)) begin
                        n_byte_idx = '0;
                        n_sending  = 1'b0;
                    end else begin
                        n_byte_idx = r_byte_idx + 1'b1;
                    end
                end else begin
                    n_bit_idx = r_bit_idx + 1'b1;
                end
            end
        end
    end

    // Line level for the next state: start bit, data LSB first, stop bits
    assign data_pos = n_bit_idx - 1'b1;
    assign byte_sel = 2'(n_byte_idx);

    always_comb begin
        n_line = 1'b1;
        if (n_sending) begin
            if (n_bit_idx == '0) begin
                n_line = 1'b0;
            end else if (int'(n_bit_idx) <= DATA_BITS) begin
                if (int'(data_pos) < 8 && int'(n_byte_idx) < BUILT_BYTES) begin
                    n_line = n_frame[byte_sel][3'(data_pos)];
                end else begin
                    n_line = 1'b0;
                end
            end
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx  <= '0;
            r_bit_idx   <= '0;
            r_tick_cnt  <= '0;
            r_sending   <= 1'b0;
            r_out_valid <= 1'b0;
            r_line      <= 1'b1;
            r_busy      <= 1'b0;
            r_rej       <= 1'b0;
        end else begin
            if (accept) begin
                r_byte_idx  <= n_byte_idx;
                r_bit_idx   <= n_bit_idx;
                r_tick_cnt  <= n_tick_cnt;
                r_sending   <= n_sending;
                r_out_valid <= 1'b1;
                r_line      <= n_line;
                r_busy      <= n_sending;
                r_rej       <= n_rej;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame bytes are payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_frame <= n_frame;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.line_level       = r_line;
    assign o_res.busy_res         = r_busy;
    assign o_res.command_rejected = r_rej;

    // Checks
    a_reject_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.action == ACT_COMMAND && r_sending) |=> (r_rej && r_busy))
        else $error("command during a frame not flagged as rejected");

    a_idle_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_busy) |-> r_line)
        else $error("line not high while idle");

    a_tick_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_tick_cnt == '0))
        else $error("tick counter not cleared while idle");

    a_byte_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_byte_idx) < FRAME_BYTES)
        else $error("byte index beyond frame");

    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_busy == r_sending))
        else $error("busy result differs from transmit state");

endmodule

`default_nettype wire
